// ----- hdl/gmatch_pkg.sv -----
// Shared types and constants for the glob name matcher.
package gmatch_pkg;

    // Default store sizes
    localparam int PATTERN_MAX_DEF = 64;
    localparam int NAME_MAX_DEF    = 256;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;

    // Characters with meaning in a pattern or a path
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_QUES   = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    // Class of a queued beat
    typedef enum logic [2:0] {
        K_PAT_CHAR   = 3'd0,
        K_PAT_END    = 3'd1,
        K_PATH_CHAR  = 3'd2,
        K_PATH_SLASH = 3'd3,
        K_PATH_END   = 3'd4
    } t_kind;

    // Queue entry: class plus the byte
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_qent;

endpackage

// ----- hdl/gmatch_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gmatch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/gmatch_front.sv -----
// Front end: classifies incoming beats and queues them for the back end.
module gmatch_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,
    input  logic              i_s_tuser,
    output logic              o_q_valid,
    output gmatch_pkg::t_qent o_q_ent,
    input  logic              i_q_pop
);

    localparam int PTRW = $clog2(gmatch_pkg::QDEPTH);
    localparam int CNTW = $clog2(gmatch_pkg::QDEPTH + 1);

    gmatch_pkg::t_qent r_q [gmatch_pkg::QDEPTH];
    logic [PTRW-1:0]   r_wptr, n_wptr;
    logic [PTRW-1:0]   r_rptr, n_rptr;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              push;
    gmatch_pkg::t_qent cls;

    // Classify the incoming byte
    always_comb begin
        cls.ch = i_s_tdata;
        if (!i_s_tuser) begin
            cls.kind = (i_s_tdata == gmatch_pkg::CH_NUL) ? gmatch_pkg::K_PAT_END
                                                        : gmatch_pkg::K_PAT_CHAR;
        end else if (i_s_tdata == gmatch_pkg::CH_NUL) begin
            cls.kind = gmatch_pkg::K_PATH_END;
        end else if (i_s_tdata == gmatch_pkg::CH_SLASH) begin
            cls.kind = gmatch_pkg::K_PATH_SLASH;
        end else begin
            cls.kind = gmatch_pkg::K_PATH_CHAR;
        end
    end

    assign o_s_tready = (r_cnt != CNTW'(gmatch_pkg::QDEPTH));
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_ent    = r_q[r_rptr];

    // Queue pointers and fill count
    always_comb begin
        n_wptr = push ? r_wptr + PTRW'(1) : r_wptr;
        n_rptr = i_q_pop ? r_rptr + PTRW'(1) : r_rptr;
        n_cnt  = r_cnt;
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

endmodule

// ----- hdl/gmatch_back.sv -----
// Back end: pattern and name stores, match sequencer and result register.
module gmatch_back #(
    parameter int PATTERN_MAX = gmatch_pkg::PATTERN_MAX_DEF,
    parameter int NAME_MAX    = gmatch_pkg::NAME_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  gmatch_pkg::t_qent i_q_ent,
    output logic              o_q_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic              o_matched,
    output logic              o_overflow
);

    localparam int PAW = $clog2(PATTERN_MAX);
    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int PW  = $clog2(PATTERN_MAX + 2);
    localparam int NAW = $clog2(NAME_MAX);
    localparam int NLW = $clog2(NAME_MAX + 1);
    localparam int TW  = $clog2(NAME_MAX + 2);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_TOP   = 7'b0000100,
        S_ESC   = 7'b0001000,
        S_BRK   = 7'b0010000,
        S_BESC  = 7'b0100000,
        S_BEND  = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    t_state          r_ret, n_ret;
    logic [PLW-1:0]  r_plen, n_plen;
    logic [NLW-1:0]  r_nlen, n_nlen;
    logic            r_loading, n_loading;
    logic [1:0]      r_ovf, n_ovf;
    logic [PW-1:0]   r_p, n_p, r_rp, n_rp;
    logic [TW-1:0]   r_t, n_t, r_rt, n_rt;
    logic            r_star, n_star;
    logic            r_found, n_found;
    logic            r_p_in, n_p_in;
    logic            r_t_in, n_t_in;
    logic            r_res_valid, n_res_valid;
    logic            r_matched, n_matched;
    logic            r_overflow, n_overflow;

    logic            pop;
    logic [PLW-1:0]  plen_base;
    logic            pat_we, name_we;
    logic [7:0]      pat_rdata, name_rdata;
    logic [7:0]      pd, nd;
    logic            fin, fin_m;

    // Stores
    gmatch_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (plen_base[PAW-1:0]),
        .i_wdata (i_q_ent.ch),
        .i_raddr (r_p[PAW-1:0]),
        .o_rdata (pat_rdata)
    );

    gmatch_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (r_nlen[NAW-1:0]),
        .i_wdata (i_q_ent.ch),
        .i_raddr (r_t[NAW-1:0]),
        .o_rdata (name_rdata)
    );

    // Pop a beat when idle; a terminator also needs the result slot free
    assign pop = (r_state == S_IDLE) && i_q_valid &&
                 ((i_q_ent.kind != gmatch_pkg::K_PATH_END) || !r_res_valid);

    assign plen_base = r_loading ? r_plen : '0;
    assign pat_we    = pop && (i_q_ent.kind == gmatch_pkg::K_PAT_CHAR) &&
                       (plen_base < PLW'(PATTERN_MAX));
    assign name_we   = pop && (i_q_ent.kind == gmatch_pkg::K_PATH_CHAR) &&
                       (r_nlen < NLW'(NAME_MAX));

    // Reads past the stored length see the terminator
    assign pd = r_p_in ? pat_rdata : gmatch_pkg::CH_NUL;
    assign nd = r_t_in ? name_rdata : gmatch_pkg::CH_NUL;

    // Load handling and match sequencer
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_plen      = r_plen;
        n_nlen      = r_nlen;
        n_loading   = r_loading;
        n_ovf       = r_ovf;
        n_p         = r_p;
        n_t         = r_t;
        n_rp        = r_rp;
        n_rt        = r_rt;
        n_star      = r_star;
        n_found     = r_found;
        n_p_in      = r_p_in;
        n_t_in      = r_t_in;
        n_res_valid = r_res_valid;
        n_matched   = r_matched;
        n_overflow  = r_overflow;
        fin         = 1'b0;
        fin_m       = 1'b0;

        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (pop) begin
                    if (i_q_ent.kind == gmatch_pkg::K_PAT_CHAR ||
                        i_q_ent.kind == gmatch_pkg::K_PAT_END) begin
                        if (!r_loading) begin
                            n_ovf[0] = 1'b0;
                        end
                        n_plen    = plen_base;
                        n_loading = 1'b1;
                        if (i_q_ent.kind == gmatch_pkg::K_PAT_END) begin
                            n_loading = 1'b0;
                        end else if (pat_we) begin
                            n_plen = plen_base + PLW'(1);
                        end else begin
                            n_ovf[0] = 1'b1;
                        end
                    end else begin
                        n_loading = 1'b0;
                        if (i_q_ent.kind == gmatch_pkg::K_PATH_SLASH) begin
                            n_nlen   = '0;
                            n_ovf[1] = 1'b0;
                        end else if (i_q_ent.kind == gmatch_pkg::K_PATH_CHAR) begin
                            if (name_we) begin
                                n_nlen = r_nlen + NLW'(1);
                            end else begin
                                n_ovf[1] = 1'b1;
                            end
                        end else if (r_ovf != 2'b00) begin
                            n_res_valid = 1'b1;
                            n_matched   = 1'b0;
                            n_overflow  = 1'b1;
                            n_nlen      = '0;
                            n_ovf[1]    = 1'b0;
                        end else begin
                            n_p     = '0;
                            n_t     = '0;
                            n_rp    = '0;
                            n_rt    = '0;
                            n_star  = 1'b0;
                            n_found = 1'b0;
                            n_ret   = S_TOP;
                            n_state = S_FETCH;
                        end
                    end
                end
            end

            // Addresses r_p / r_t are at the RAMs this cycle
            S_FETCH: begin
                n_p_in  = (r_p < PW'(r_plen));
                n_t_in  = (r_t < TW'(r_nlen));
                n_state = r_ret;
            end

            S_TOP, S_ESC: begin
                n_state = S_FETCH;
                n_ret   = S_TOP;
                n_p     = r_p + PW'(1);
                if (r_state == S_TOP && nd == gmatch_pkg::CH_NUL &&
                    pd == gmatch_pkg::CH_NUL) begin
                    fin   = 1'b1;
                    fin_m = 1'b1;
                end else if (r_state == S_TOP && pd == gmatch_pkg::CH_STAR) begin
                    n_rp   = r_p + PW'(1);
                    n_rt   = r_t;
                    n_star = 1'b1;
                end else if (r_state == S_TOP && pd == gmatch_pkg::CH_LBRK) begin
                    n_found = 1'b0;
                    n_ret   = S_BRK;
                end else if (r_state == S_TOP && pd == gmatch_pkg::CH_QUES) begin
                    if (nd == gmatch_pkg::CH_NUL) begin
                        fin = 1'b1;
                    end else begin
                        n_t = r_t + TW'(1);
                    end
                end else if (r_state == S_TOP && pd == gmatch_pkg::CH_BSLASH) begin
                    n_ret = S_ESC;
                end else if (r_state == S_ESC && pd == gmatch_pkg::CH_NUL) begin
                    // trailing backslash
                    fin = 1'b1;
                end else if (nd == pd) begin
                    if (pd != gmatch_pkg::CH_NUL) begin
                        n_t = r_t + TW'(1);
                    end
                end else if (nd != gmatch_pkg::CH_NUL) begin
                    if (!r_star) begin
                        fin = 1'b1;
                    end else begin
                        n_p  = r_rp;
                        n_rt = r_rt + TW'(1);
                        n_t  = r_rt + TW'(1);
                    end
                end else begin
                    fin = 1'b1;
                end
            end

            S_BRK, S_BESC: begin
                n_state = S_FETCH;
                n_ret   = S_BRK;
                n_p     = r_p + PW'(1);
                if (r_state == S_BRK && pd == gmatch_pkg::CH_RBRK) begin
                    if (!r_found) begin
                        if (!r_star) begin
                            fin = 1'b1;
                        end else begin
                            n_p   = r_rp;
                            n_rt  = r_rt + TW'(1);
                            n_t   = r_rt + TW'(1);
                            n_ret = S_BEND;
                        end
                    end else if (nd == gmatch_pkg::CH_NUL) begin
                        fin = 1'b1;
                    end else begin
                        n_t   = r_t + TW'(1);
                        n_ret = S_TOP;
                    end
                end else if (r_state == S_BRK && pd == gmatch_pkg::CH_BSLASH) begin
                    n_ret = S_BESC;
                end else if (pd == gmatch_pkg::CH_NUL) begin
                    // unterminated set
                    fin = 1'b1;
                end else if (nd == pd) begin
                    n_found = 1'b1;
                end
            end

            // Restart after a failed set consumes one name character
            S_BEND: begin
                n_state = S_FETCH;
                n_ret   = S_TOP;
                if (nd == gmatch_pkg::CH_NUL) begin
                    fin = 1'b1;
                end else begin
                    n_t = r_t + TW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Match finished: post the result and drop the basename
        if (fin) begin
            n_state     = S_IDLE;
            n_res_valid = 1'b1;
            n_matched   = fin_m;
            n_overflow  = 1'b0;
            n_nlen      = '0;
            n_ovf[1]    = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_TOP;
            r_plen      <= '0;
            r_nlen      <= '0;
            r_loading   <= 1'b0;
            r_ovf       <= 2'b00;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_plen      <= n_plen;
            r_nlen      <= n_nlen;
            r_loading   <= n_loading;
            r_ovf       <= n_ovf;
            r_res_valid <= n_res_valid;
        end
    end

    // Walk pointers and result payload
    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_t        <= n_t;
        r_rp       <= n_rp;
        r_rt       <= n_rt;
        r_star     <= n_star;
        r_found    <= n_found;
        r_p_in     <= n_p_in;
        r_t_in     <= n_t_in;
        r_matched  <= n_matched;
        r_overflow <= n_overflow;
    end

    assign o_q_pop     = pop;
    assign o_res_valid = r_res_valid;
    assign o_matched   = r_matched;
    assign o_overflow  = r_overflow;

endmodule

// ----- hdl/glob_name_matcher_unit.sv -----
// Top level of the glob name matcher: front queue, back end, result port.
//
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] = char_in, tuser[0] = mode (0 pattern, 1 path)
//  m_axis    out  tdata[0] = matched, tdata[1] = overflow, tdata[7:2] = 0
//
// Bytes load at one beat per cycle through a four-entry queue. At a path
// terminator the walk runs step by step (RAM read, then decide): one
// step per pattern byte visited, rereads after a star restart included, one
// after a failed set and one for the end check. Reset clears lengths, flags
// and queue; the stores need no clearing pass. A walk stalls the queue, a result
// not yet taken stalls a terminator at its head; four waiting beats drop tready.
module glob_name_matcher_unit #(
    parameter int PATTERN_MAX = gmatch_pkg::PATTERN_MAX_DEF,
    parameter int NAME_MAX    = gmatch_pkg::NAME_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tuser,   // [0] mode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    logic              q_valid;
    gmatch_pkg::t_qent q_ent;
    logic              q_pop;
    logic              res_matched;
    logic              res_overflow;

    gmatch_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_q_valid  (q_valid),
        .o_q_ent    (q_ent),
        .i_q_pop    (q_pop)
    );

    gmatch_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .NAME_MAX    (NAME_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_ent     (q_ent),
        .o_q_pop     (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_matched   (res_matched),
        .o_overflow  (res_overflow)
    );

    // Pack the result beat
    assign m_axis_tdata = {6'b000000, res_overflow, res_matched};

endmodule
